@@ rtl/picl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picl_pkg: shared types and constants of the PI current loop
// Item and result layouts, register map and the fixed numbers of the loop.
// ----------------------------------------------------------------------------
package picl_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Item field widths
    localparam int CUR_W   = 10;
    localparam int PWM_W   = 9;
    localparam int SR_W    = 10;
    localparam int FB_W    = 12;
    localparam int AVG_W   = 16;
    localparam int ERR_W   = 13;
    localparam int ACC_W   = 32;
    localparam int AVG_SEL_W = 2;

    // Loop constants
    localparam int SR_DEAD_TIME   = 8;
    localparam int VREF_RAW_MIN   = 102;
    localparam int FB_GAIN        = 19;
    localparam int FB_FRAC        = 3;
    localparam int LEVEL_MAX      = 508;
    localparam int LEVEL_SAT      = 510;
    localparam int PWM_SAT        = 511;
    localparam int SR_FULL        = 512;
    localparam int SR_CUR_MIN     = 10;
    localparam int AVG_SHIFT_BASE = 7;
    localparam int AVG_FRAC       = 7;

    // Register reset values
    localparam int RST_ZERO_OFFSET = 512;
    localparam int RST_CUR_LIMIT   = 1023;

    typedef enum logic [2:0] {
        REG_KP          = 3'd0,
        REG_KI          = 3'd1,
        REG_ZERO_OFFSET = 3'd2,
        REG_PWM_LIMIT   = 3'd3,
        REG_CUR_LIMIT   = 3'd4,
        REG_AVG_SEL     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [ACC_W-1:0] kp;
        logic signed [ACC_W-1:0] ki;
        logic [CUR_W-1:0]        zero_offset;
        logic [PWM_W-1:0]        pwm_limit;
        logic [CUR_W-1:0]        cur_limit;
        logic [AVG_SEL_W-1:0]    avg_sel;
    } t_cfg;

    typedef struct packed {
        logic [CUR_W-1:0] raw_current;
        logic [CUR_W-1:0] current_target;
        logic [PWM_W-1:0] throttle_level;
        logic [CUR_W-1:0] current_ceiling;
        logic             other_fault;
    } t_in_item;

    typedef struct packed {
        logic [PWM_W-1:0] duty_width;
        logic [SR_W-1:0]  sr_width;
        logic             vref_flag;
        logic [FB_W-1:0]  norm_current;
        logic [CUR_W-1:0] peak_current;
        logic [AVG_W-1:0] pwm_average;
        logic             fault_off;
    } t_out_item;

endpackage

@@ rtl/picl_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picl_in_if: sample channel
// Valid/ready channel carrying one current sample with its loop inputs.
// ----------------------------------------------------------------------------
interface picl_in_if;
    logic                        valid;
    logic                        ready;
    logic [picl_pkg::CUR_W-1:0]  raw_current;
    logic [picl_pkg::CUR_W-1:0]  current_target;
    logic [picl_pkg::PWM_W-1:0]  throttle_level;
    logic [picl_pkg::CUR_W-1:0]  current_ceiling;
    logic                        other_fault;

    modport source (
        output valid, raw_current, current_target, throttle_level,
               current_ceiling, other_fault,
        input  ready
    );
    modport sink (
        input  valid, raw_current, current_target, throttle_level,
               current_ceiling, other_fault,
        output ready
    );
endinterface

@@ rtl/picl_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picl_out_if: result channel
// Valid/ready channel carrying the pulse widths and loop status of one sample.
// ----------------------------------------------------------------------------
interface picl_out_if;
    logic                        valid;
    logic                        ready;
    logic [picl_pkg::PWM_W-1:0]  duty_width;
    logic [picl_pkg::SR_W-1:0]   sr_width;
    logic                        vref_flag;
    logic [picl_pkg::FB_W-1:0]   norm_current;
    logic [picl_pkg::CUR_W-1:0]  peak_current;
    logic [picl_pkg::AVG_W-1:0]  pwm_average;
    logic                        fault_off;

    modport source (
        output valid, duty_width, sr_width, vref_flag, norm_current,
               peak_current, pwm_average, fault_off,
        input  ready
    );
    modport sink (
        input  valid, duty_width, sr_width, vref_flag, norm_current,
               peak_current, pwm_average, fault_off,
        output ready
    );
endinterface

@@ rtl/picl_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picl_regs: configuration registers
// APB-style register file holding the gains, offsets and limits of the loop.
// ----------------------------------------------------------------------------
module picl_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [picl_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [picl_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [picl_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output picl_pkg::t_cfg                      o_cfg
);

    picl_pkg::t_cfg     r_cfg;
    picl_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = picl_pkg::t_reg_idx'(paddr[picl_pkg::CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= '0;
            r_cfg.ki          <= '0;
            r_cfg.zero_offset <= picl_pkg::CUR_W'(picl_pkg::RST_ZERO_OFFSET);
            r_cfg.pwm_limit   <= '0;
            r_cfg.cur_limit   <= picl_pkg::CUR_W'(picl_pkg::RST_CUR_LIMIT);
            r_cfg.avg_sel     <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                picl_pkg::REG_KP:          r_cfg.kp          <= pwdata;
                picl_pkg::REG_KI:          r_cfg.ki          <= pwdata;
                picl_pkg::REG_ZERO_OFFSET: r_cfg.zero_offset <= pwdata[picl_pkg::CUR_W-1:0];
                picl_pkg::REG_PWM_LIMIT:   r_cfg.pwm_limit   <= pwdata[picl_pkg::PWM_W-1:0];
                picl_pkg::REG_CUR_LIMIT:   r_cfg.cur_limit   <= pwdata[picl_pkg::CUR_W-1:0];
                picl_pkg::REG_AVG_SEL:     r_cfg.avg_sel     <= pwdata[picl_pkg::AVG_SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            picl_pkg::REG_KP:          prdata = r_cfg.kp;
            picl_pkg::REG_KI:          prdata = r_cfg.ki;
            picl_pkg::REG_ZERO_OFFSET: prdata = picl_pkg::CFG_DATA_W'(r_cfg.zero_offset);
            picl_pkg::REG_PWM_LIMIT:   prdata = picl_pkg::CFG_DATA_W'(r_cfg.pwm_limit);
            picl_pkg::REG_CUR_LIMIT:   prdata = picl_pkg::CFG_DATA_W'(r_cfg.cur_limit);
            picl_pkg::REG_AVG_SEL:     prdata = picl_pkg::CFG_DATA_W'(r_cfg.avg_sel);
            default:                   prdata = '0;
        endcase
    end

endmodule

@@ rtl/picl_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picl_core: current loop datapath
// Feedback scaling, peak tracking, direct/PI width selection, current clip,
// rectifier width and PWM average, with loop state and the result register.
// ----------------------------------------------------------------------------
module picl_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  picl_pkg::t_cfg       i_cfg,
    input  picl_pkg::t_in_item   i_item,
    input  logic                 i_load,
    output picl_pkg::t_out_item  o_result
);

    localparam int CUR_W = picl_pkg::CUR_W;
    localparam int PWM_W = picl_pkg::PWM_W;
    localparam int ERR_W = picl_pkg::ERR_W;
    localparam int ACC_W = picl_pkg::ACC_W;
    localparam int AVG_W = picl_pkg::AVG_W;
    localparam int FB_W  = picl_pkg::FB_W;
    localparam int SR_W  = picl_pkg::SR_W;
    localparam int HALF  = ACC_W / 2;
    localparam int FBP_W = CUR_W + 5;
    localparam int DIF_W = AVG_W + 2;

    // Loop state
    logic [ACC_W-1:0]        r_acc;
    logic signed [ERR_W-1:0] r_prev_err;
    logic [AVG_W-1:0]        r_avg;
    logic [CUR_W-1:0]        r_peak;
    picl_pkg::t_out_item     r_result;

    logic [ACC_W-1:0]        n_acc;
    logic signed [ERR_W-1:0] n_prev_err;
    logic [AVG_W-1:0]        n_avg;
    logic [CUR_W-1:0]        n_peak;
    picl_pkg::t_out_item     n_result;

    logic signed [CUR_W:0]     w_mc;
    logic                      w_mc_neg;
    logic [CUR_W-1:0]          w_mc_mag;
    logic [FBP_W-1:0]          w_fb_prod;
    logic [FB_W-1:0]           w_fb;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [ACC_W+ERR_W-1:0] w_p_kp;
    logic signed [ACC_W+ERR_W-1:0] w_p_ki;
    logic [ACC_W-1:0]          w_acc_sum;
    logic [PWM_W-1:0]          w_width;
    logic [PWM_W-1:0]          w_direct;
    logic                      w_fault_off;
    logic [SR_W-1:0]           w_sr;
    logic [2:0]                w_shift;
    logic signed [DIF_W-1:0]   w_diff;
    logic signed [DIF_W-1:0]   w_step;

    always_comb begin
        w_mc     = $signed({1'b0, i_cfg.zero_offset}) - $signed({1'b0, i_item.raw_current});
        w_mc_neg = w_mc[CUR_W];
        w_mc_mag = w_mc[CUR_W-1:0];

        w_fb_prod = FBP_W'(w_mc_mag) * FBP_W'(picl_pkg::FB_GAIN);
        w_fb      = w_mc_neg ? '0 : FB_W'(w_fb_prod >> picl_pkg::FB_FRAC);

        n_peak = (!w_mc_neg && (w_mc_mag > r_peak)) ? w_mc_mag : r_peak;

        w_err  = $signed(ERR_W'(i_item.current_target)) - $signed({1'b0, w_fb});
        w_p_kp = i_cfg.kp * w_err;
        w_p_ki = i_cfg.ki * r_prev_err;
        w_acc_sum = r_acc + w_p_kp[ACC_W-1:0] + w_p_ki[ACC_W-1:0];

        w_direct = (i_item.throttle_level < i_cfg.pwm_limit)
                 ? i_item.throttle_level : i_cfg.pwm_limit;

        n_acc       = r_acc;
        n_prev_err  = r_prev_err;
        w_fault_off = 1'b0;
        w_width     = '0;

        if (i_cfg.pwm_limit != '0) begin
            // Direct mode leaves the PI state alone
            if (i_item.other_fault) begin
                w_fault_off = 1'b1;
            end else if (w_fb <= FB_W'(i_item.current_ceiling)) begin
                w_width = w_direct;
            end
        end else if (i_item.current_target == '0) begin
            n_acc      = '0;
            n_prev_err = '0;
        end else begin
            n_prev_err = w_err;
            if (w_acc_sum[ACC_W-1]) begin
                n_acc = '0;
            end else if (w_acc_sum[ACC_W-2:HALF] > (HALF-1)'(picl_pkg::LEVEL_MAX)) begin
                n_acc   = ACC_W'(picl_pkg::LEVEL_SAT) << HALF;
                w_width = PWM_W'(picl_pkg::PWM_SAT);
            end else begin
                // Round on the top fraction bit
                n_acc   = w_acc_sum;
                w_width = PWM_W'(w_acc_sum[ACC_W-2:HALF]) + PWM_W'(w_acc_sum[HALF-1]);
            end
        end

        // Hard current clip
        if (!w_mc_neg && (w_mc_mag > i_cfg.cur_limit)) begin
            w_width = '0;
        end

        if (w_width != '0) begin
            w_sr = SR_W'(w_width) + SR_W'(picl_pkg::SR_DEAD_TIME);
        end else if (!w_mc_neg && (w_mc_mag > CUR_W'(picl_pkg::SR_CUR_MIN))) begin
            w_sr = '0;
        end else begin
            w_sr = SR_W'(picl_pkg::SR_FULL);
        end

        // Arithmetic shift floors toward minus infinity
        w_shift = 3'(picl_pkg::AVG_SHIFT_BASE) - {1'b0, i_cfg.avg_sel};
        w_diff  = $signed({2'b00, w_width, picl_pkg::AVG_FRAC'(0)})
                - $signed({2'b00, r_avg});
        w_step  = w_diff >>> w_shift;
        n_avg   = r_avg + w_step[AVG_W-1:0];

        n_result.duty_width       = w_width;
        n_result.sr_width         = w_sr;
        n_result.vref_flag        = w_mc_neg &&
                                    (i_item.raw_current < CUR_W'(picl_pkg::VREF_RAW_MIN));
        n_result.norm_current     = w_fb;
        n_result.peak_current     = n_peak;
        n_result.pwm_average      = n_avg;
        n_result.fault_off        = w_fault_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_prev_err <= '0;
            r_avg      <= '0;
            r_peak     <= '0;
        end else if (i_load) begin
            r_acc      <= n_acc;
            r_prev_err <= n_prev_err;
            r_avg      <= n_avg;
            r_peak     <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

@@ rtl/pi_current_loop_pwm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_current_loop_pwm: motor current loop with PWM output
// Scales the current sample, selects direct or PI pulse width, clips on
// overcurrent and derives rectifier width and a filtered PWM average.
// ----------------------------------------------------------------------------
//  channel   dir   kind          contents
//  i_in      in    valid/ready   current sample, target, throttle, ceiling, fault
//  o_out     out   valid/ready   pwm/sr width, feedback, peak, average, status
//  apb       in    APB write/rd  gains, zero offset, limits, average select
//
//  One beat per cycle sustained while o_out is not stalled; o_out.valid rises
//  once a sample beat has passed the input register and then the result
//  register behind the loop math.
//  The PI accumulator, previous error, average and peak update as a result
//  is registered, so the next sample already sees the updated loop state.
//  A stalled o_out holds the result; the input register still takes one beat.
//  Synchronous reset clears the loop state and loads register defaults.
// ----------------------------------------------------------------------------
module pi_current_loop_pwm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    picl_in_if.sink                           i_in,
    picl_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [picl_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [picl_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [picl_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    picl_pkg::t_cfg      w_cfg;
    picl_pkg::t_in_item  r_item;
    picl_pkg::t_out_item w_result;
    logic                r_in_valid;
    logic                r_out_valid;
    logic                w_load;
    logic                w_in_ready;

    picl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance into the result register when it is empty or being drained
    assign w_load     = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_load;
    assign i_in.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_item.raw_current     <= i_in.raw_current;
            r_item.current_target  <= i_in.current_target;
            r_item.throttle_level  <= i_in.throttle_level;
            r_item.current_ceiling <= i_in.current_ceiling;
            r_item.other_fault     <= i_in.other_fault;
        end
    end

    picl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_item   (r_item),
        .i_load   (w_load),
        .o_result (w_result)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.duty_width       = w_result.duty_width;
    assign o_out.sr_width         = w_result.sr_width;
    assign o_out.vref_flag        = w_result.vref_flag;
    assign o_out.norm_current     = w_result.norm_current;
    assign o_out.peak_current     = w_result.peak_current;
    assign o_out.pwm_average      = w_result.pwm_average;
    assign o_out.fault_off        = w_result.fault_off;

endmodule

@@ bench/pi_current_loop_pwm_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_current_loop_pwm_tb: self-checking bench for the PI current loop
// Drives current samples through the valid/ready channels under several
// register settings, predicts every result beat from a cycle-free model of
// the loop and compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module pi_current_loop_pwm_tb;

    localparam int IDLE_LIMIT  = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 205;
    localparam int NUM_PHASES  = 9;

    localparam int CUR_W      = picl_pkg::CUR_W;
    localparam int PWM_W      = picl_pkg::PWM_W;
    localparam int SR_W       = picl_pkg::SR_W;
    localparam int FB_W       = picl_pkg::FB_W;
    localparam int AVG_SEL_W  = picl_pkg::AVG_SEL_W;
    localparam int CFG_ADDR_W = picl_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = picl_pkg::CFG_DATA_W;

    // Holds the loop state and the expected result beats in order.
    class pwm_scoreboard;
        picl_pkg::t_cfg      cfg;
        logic [31:0]         pi_acc;
        int                  prev_err;
        logic [15:0]         avg_q;
        logic [9:0]          peak_q;
        picl_pkg::t_out_item pending_pwm[$];
        int                  mismatches;
        int                  checked;

        function new();
            cfg.kp          = '0;
            cfg.ki          = '0;
            cfg.zero_offset = CUR_W'(picl_pkg::RST_ZERO_OFFSET);
            cfg.pwm_limit   = '0;
            cfg.cur_limit   = CUR_W'(picl_pkg::RST_CUR_LIMIT);
            cfg.avg_sel     = '0;
            pi_acc     = '0;
            prev_err   = 0;
            avg_q      = '0;
            peak_q     = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(picl_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                picl_pkg::REG_KP:          cfg.kp          = value;
                picl_pkg::REG_KI:          cfg.ki          = value;
                picl_pkg::REG_ZERO_OFFSET: cfg.zero_offset = value[CUR_W-1:0];
                picl_pkg::REG_PWM_LIMIT:   cfg.pwm_limit   = value[PWM_W-1:0];
                picl_pkg::REG_CUR_LIMIT:   cfg.cur_limit   = value[CUR_W-1:0];
                picl_pkg::REG_AVG_SEL:     cfg.avg_sel     = value[AVG_SEL_W-1:0];
                default: ;
            endcase
        endfunction

        function picl_pkg::t_out_item predict_pwm(picl_pkg::t_in_item s);
            picl_pkg::t_out_item r;
            int          mc;
            int          fb;
            int          err;
            int          level;
            int          width;
            int          sr;
            int          diff;
            logic [15:0] top;
            mc = int'(cfg.zero_offset) - int'(s.raw_current);
            r.vref_flag = 1'b0;
            r.fault_off = 1'b0;
            if (mc < 0) begin
                fb = 0;
                if (s.raw_current < picl_pkg::VREF_RAW_MIN) r.vref_flag = 1'b1;
            end else begin
                fb = (mc * picl_pkg::FB_GAIN) >>> picl_pkg::FB_FRAC;
            end
            if (mc > int'(peak_q)) peak_q = mc[9:0];

            if (cfg.pwm_limit != 0) begin
                if (s.other_fault) begin
                    r.fault_off = 1'b1;
                    width = 0;
                end else if (fb > int'(s.current_ceiling)) begin
                    width = 0;
                end else if (s.throttle_level < cfg.pwm_limit) begin
                    width = int'(s.throttle_level);
                end else begin
                    width = int'(cfg.pwm_limit);
                end
            end else if (s.current_target == 0) begin
                pi_acc   = '0;
                prev_err = 0;
                width    = 0;
            end else begin
                err = int'(s.current_target) - fb;
                // wraps modulo 2^32 like the hardware accumulator
                pi_acc = pi_acc + $unsigned(cfg.kp) * $unsigned(err)
                       + $unsigned(cfg.ki) * $unsigned(prev_err);
                prev_err = err;
                top   = pi_acc[31:16];
                level = int'($signed(top));
                if (level < 0) begin
                    pi_acc = '0;
                    width  = 0;
                end else if (level > picl_pkg::LEVEL_MAX) begin
                    pi_acc = 32'(picl_pkg::LEVEL_SAT) << 16;
                    width  = picl_pkg::PWM_SAT;
                end else begin
                    width = level + int'(pi_acc[15]);
                end
            end

            if (mc > int'(cfg.cur_limit)) width = 0;

            if (width > 0) sr = width + picl_pkg::SR_DEAD_TIME;
            else sr = (mc > picl_pkg::SR_CUR_MIN) ? 0 : picl_pkg::SR_FULL;

            // arithmetic shift rounds toward minus infinity
            diff  = (width << picl_pkg::AVG_FRAC) - int'(avg_q);
            avg_q = avg_q + 16'(diff >>> (picl_pkg::AVG_SHIFT_BASE - int'(cfg.avg_sel)));

            r.duty_width   = width[PWM_W-1:0];
            r.sr_width     = sr[SR_W-1:0];
            r.norm_current = fb[FB_W-1:0];
            r.peak_current = peak_q;
            r.pwm_average  = avg_q;
            return r;
        endfunction

        function void note_sample(picl_pkg::t_in_item s);
            pending_pwm.push_back(predict_pwm(s));
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 100) $display("MISMATCH result %0d: %s", checked, what);
        endtask

        task check_result(picl_pkg::t_out_item got);
            picl_pkg::t_out_item want;
            if (pending_pwm.size() == 0) begin
                report("result beat with no sample waiting");
                return;
            end
            want = pending_pwm.pop_front();
            if (got.duty_width !== want.duty_width)
                report($sformatf("duty_width %0d, expected %0d",
                                 got.duty_width, want.duty_width));
            if (got.sr_width !== want.sr_width)
                report($sformatf("sr_width %0d, expected %0d", got.sr_width, want.sr_width));
            if (got.vref_flag !== want.vref_flag)
                report($sformatf("vref_flag %0b, expected %0b",
                                 got.vref_flag, want.vref_flag));
            if (got.norm_current !== want.norm_current)
                report($sformatf("norm_current %0d, expected %0d",
                                 got.norm_current, want.norm_current));
            if (got.peak_current !== want.peak_current)
                report($sformatf("peak_current %0d, expected %0d",
                                 got.peak_current, want.peak_current));
            if (got.pwm_average !== want.pwm_average)
                report($sformatf("pwm_average %0d, expected %0d",
                                 got.pwm_average, want.pwm_average));
            if (got.fault_off !== want.fault_off)
                report($sformatf("fault_off %0b, expected %0b", got.fault_off, want.fault_off));
            checked++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    picl_in_if  in_if ();
    picl_out_if out_if ();

    pwm_scoreboard sb;
    bit            idle_on;
    int            hold_req;
    bit            took_result;
    int            idle_cycles;

    pi_current_loop_pwm dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample both channels at the rising edge; also watch for a stuck run.
    always @(posedge i_clk) begin
        picl_pkg::t_in_item  s;
        picl_pkg::t_out_item got;
        if (in_if.valid && in_if.ready && i_rst_n) begin
            s.raw_current     = in_if.raw_current;
            s.current_target  = in_if.current_target;
            s.throttle_level  = in_if.throttle_level;
            s.current_ceiling = in_if.current_ceiling;
            s.other_fault     = in_if.other_fault;
            sb.note_sample(s);
            idle_cycles = 0;
        end else if (!(out_if.valid && out_if.ready)) begin
            idle_cycles++;
        end
        if (out_if.valid && out_if.ready && i_rst_n) begin
            got.duty_width   = out_if.duty_width;
            got.sr_width     = out_if.sr_width;
            got.vref_flag    = out_if.vref_flag;
            got.norm_current = out_if.norm_current;
            got.peak_current = out_if.peak_current;
            got.pwm_average  = out_if.pwm_average;
            got.fault_off    = out_if.fault_off;
            sb.check_result(got);
            took_result = 1'b1;
            idle_cycles = 0;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stall before each beat, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        int hold;
        out_if.ready = 1'b0;
        gap  = 0;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold     = hold_req;
                hold_req = 0;
            end
            if (took_result) begin
                gap         = idle_on ? $urandom_range(0, 3) : 0;
                took_result = 1'b0;
            end
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else if (gap > 0) begin
                out_if.ready <= 1'b0;
                gap--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input picl_pkg::t_in_item s);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.raw_current     <= s.raw_current;
        in_if.current_target  <= s.current_target;
        in_if.throttle_level  <= s.throttle_level;
        in_if.current_ceiling <= s.current_ceiling;
        in_if.other_fault     <= s.other_fault;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input int raw, input int target, input int thr,
                               input int ceil_lvl, input bit fault);
        picl_pkg::t_in_item s;
        s.raw_current     = raw[CUR_W-1:0];
        s.current_target  = target[CUR_W-1:0];
        s.throttle_level  = thr[PWM_W-1:0];
        s.current_ceiling = ceil_lvl[CUR_W-1:0];
        s.other_fault     = fault;
        send_sample(s);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending_pwm.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input picl_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_setting(input logic [31:0] kp, input logic [31:0] ki,
                                input int off, input int lim, input int clim,
                                input int sel);
        wait_drained();
        repeat (4) @(negedge i_clk);
        write_reg(picl_pkg::REG_KP, kp);
        write_reg(picl_pkg::REG_KI, ki);
        write_reg(picl_pkg::REG_ZERO_OFFSET, 32'(off));
        write_reg(picl_pkg::REG_PWM_LIMIT, 32'(lim));
        write_reg(picl_pkg::REG_CUR_LIMIT, 32'(clim));
        write_reg(picl_pkg::REG_AVG_SEL, 32'(sel));
    endtask

    // Mostly samples near the zero offset so the loop tracks; some full range.
    function automatic picl_pkg::t_in_item random_sample();
        picl_pkg::t_in_item s;
        int       r;
        if ($urandom_range(0, 9) < 7) begin
            r = int'(sb.cfg.zero_offset) - int'($urandom_range(0, 48)) + 8;
            if (r < 0) r = 0;
            if (r > 1023) r = 1023;
            s.raw_current = r[CUR_W-1:0];
        end else begin
            s.raw_current = CUR_W'($urandom);
        end
        case ($urandom_range(0, 19))
            0:       s.current_target = '0;
            1, 2:    s.current_target = CUR_W'($urandom);
            default: s.current_target = CUR_W'($urandom_range(1, 160));
        endcase
        s.throttle_level  = PWM_W'($urandom);
        s.current_ceiling = CUR_W'($urandom);
        s.other_fault     = ($urandom_range(0, 7) == 0);
        return s;
    endfunction

    initial begin : stimulus
        logic [31:0] kp;
        sb          = new();
        idle_on     = 1'b1;
        hold_req    = 0;
        took_result = 1'b0;
        idle_cycles = 0;
        in_if.valid           = 1'b0;
        in_if.raw_current     = '0;
        in_if.current_target  = '0;
        in_if.throttle_level  = '0;
        in_if.current_ceiling = '0;
        in_if.other_fault     = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // PI mode: zero target clear, build-up, reversed current, saturation
        load_setting(32'd40000, -32'sd38000, 512, 0, 1023, 0);
        send_fields(512, 0, 0, 0, 0);
        send_fields(512, 100, 0, 0, 0);
        send_fields(512, 100, 0, 0, 0);
        send_fields(512, 100, 0, 0, 0);
        send_fields(0, 1023, 511, 1023, 1);
        send_fields(1023, 1023, 0, 0, 0);
        send_fields(512, 1023, 0, 0, 0);
        send_fields(512, 1023, 0, 0, 0);
        send_fields(512, 1023, 0, 0, 0);
        send_fields(500, 0, 0, 0, 0);

        // direct mode: cap, fault, ceiling, overcurrent clip, VREF edge
        load_setting(32'd0, 32'd0, 100, 511, 60, 1);
        send_fields(50, 5, 511, 1023, 0);
        send_fields(50, 5, 511, 1023, 1);
        send_fields(40, 5, 300, 100, 0);
        send_fields(0, 5, 300, 1023, 0);
        send_fields(101, 5, 0, 1023, 0);
        send_fields(102, 5, 200, 1023, 0);
        send_fields(95, 5, 0, 1023, 0);

        // extreme gains wrap the accumulator
        load_setting(32'h7FFF_FFFF, 32'h8000_0000, 1023, 0, 0, 3);
        send_fields(1023, 1023, 0, 0, 0);
        send_fields(1023, 1023, 0, 0, 0);
        send_fields(1000, 1023, 0, 0, 0);
        send_fields(0, 1, 0, 0, 0);
        send_fields(1023, 512, 0, 0, 0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_setting(32'd30000, -32'sd29000, 512, 0, 1023, 0);
                1: begin
                    kp = $urandom_range(1000, 100000);
                    load_setting(kp, -kp + $urandom_range(0, 3000),
                                 $urandom_range(400, 600), 0, 1023, 1);
                end
                2: load_setting(32'h7FFF_FFFF, 32'h8000_0000, 1023, 0, 1023, 3);
                3: load_setting($urandom, $urandom, 512, 511, 1023, 2);
                4: load_setting(32'd16000, -32'sd15000, 0, 1, 0, 3);
                5: load_setting(32'd80000, -32'sd60000, 0, 0, 600, 2);
                6: load_setting(-32'sd50000, 32'd45000, 700, 0, 300, 1);
                7: load_setting($urandom, $urandom, $urandom_range(0, 1023),
                                $urandom_range(1, 511), $urandom_range(0, 1023),
                                $urandom_range(0, 3));
                default: begin
                    kp = $urandom_range(20000, 40000);
                    load_setting(kp, -kp + 1000, 512, 0, 1023, 0);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_on = !(ph == NUM_PHASES - 1 || (n % 64) >= 48);
                // long receiver hold-off while samples keep coming
                if (ph == 2 && n == 60) hold_req = HOLD_CYCLES;
                if (ph == 5 && n == 100) wait_drained();
                send_sample(random_sample());
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
